@@ sv/pss_pkg.sv @@
// Package: shared constants and types for the polyline segment subdivider.
`timescale 1ns / 1ps
package pss_pkg;
   localparam int MAX_INTERVALS_DEF = 32;
   localparam int COORD_BITS_DEF    = 24;
   localparam int LEN_BITS          = 23;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 23'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_SEARCH,
      ST_DIV,
      ST_EMIT,
      ST_LAST
   } state_type;
endpackage

@@ sv/pss_if.sv @@
// Interface: valid/ready channel carrying one point beat.
`timescale 1ns / 1ps
interface pss_if #(parameter int COORD_BITS = 24) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x;
   logic signed [COORD_BITS-1:0] y;
   logic                         flag;
   modport source (output valid, x, y, flag, input ready);
   modport sink (input valid, x, y, flag, output ready);
endinterface

@@ sv/pss_mul.sv @@
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module pss_mul #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           done,
   output logic [2*W-1:0] prod
);
   localparam int CW = $clog2(W + 1);
   logic [2*W-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [W-1:0]   mp_ff, mp_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         mc_in   = {{W{1'b0}}, a};
         mp_in   = b;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign prod = acc_in;
endmodule

@@ sv/pss_div.sv @@
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
`timescale 1ns / 1ps
module pss_div #(
   parameter int W  = 32,
   parameter int DW = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] num,
   input  logic [DW-1:0]       den,
   output logic                done,
   output logic signed [W-1:0] quo
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff[DW-1:0], q_ff[W-1]};
      if (start) begin
         neg_in  = num[W-1];
         q_in    = num[W-1] ? W'(-num) : W'(num);
         r_in    = '0;
         d_in    = den;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign quo  = neg_ff ? -$signed(q_in) : $signed(q_in);
endmodule

@@ sv/polyline_segment_subdivider_core.sv @@
// Top level: splits long polyline segments into equal pieces.
// A start point leaves the cycle after acceptance. A later point is first squared
// in two bit-serial multiplies, then each tried count takes a multiply and a
// squaring, then each emitted interior point takes two bit-serial divides;
// output stalls add to this.
// Points are taken one at a time; the bit-serial multiplier and divider set the pace.
// Reset: synchronous, clears stored point, max_length to 1.0, channels idle.
`timescale 1ns / 1ps
module polyline_segment_subdivider_core
   import pss_pkg::*;
#(
   parameter int MAX_INTERVALS = pss_pkg::MAX_INTERVALS_DEF,
   parameter int COORD_BITS    = pss_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   pss_if.sink                         req,
   pss_if.source                       rsp,
   input  logic                        csr_we,
   input  logic [pss_pkg::LEN_BITS-1:0] csr_wdata
);
   localparam int NW = $clog2(MAX_INTERVALS + 1);
   localparam int DXW = COORD_BITS + 1;
   localparam int MW = (2 * DXW > LEN_BITS + NW) ? 2 * DXW : LEN_BITS + NW;
   localparam int QW = DXW + NW + 1;

   state_type state_ff, state_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in, bx_ff, bx_in, by_ff, by_in;
   logic have_ff, have_in;
   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [2*MW-1:0] sum_ff, sum_in, sq_ff, sq_in;
   logic [NW-1:0] n_ff, n_in, i_ff, i_in;
   logic [1:0] ph_ff, ph_in;
   logic signed [COORD_BITS-1:0] ox_ff, ox_in, oy_ff, oy_in, qx_ff, qx_in, qy_ff, qy_in;
   logic olast_ff, olast_in, ov_ff, ov_in;

   logic mstart, mdone, dstart, ddone;
   logic [MW-1:0] ma, mb;
   logic [2*MW-1:0] mprod;
   logic signed [QW-1:0] dnum, dquo;
   logic [DXW-1:0] adx, ady;

   pss_mul #(.W(MW)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .prod(mprod)
   );

   pss_div #(.W(QW), .DW(NW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(n_ff),
      .done(ddone), .quo(dquo)
   );

   assign adx = dx_ff[DXW-1] ? DXW'(-dx_ff) : DXW'(dx_ff);
   assign ady = dy_ff[DXW-1] ? DXW'(-dy_ff) : DXW'(dy_ff);
   assign req.ready = (state_ff == ST_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.x     = ox_ff;
   assign rsp.y     = oy_ff;
   assign rsp.flag  = olast_ff;

   always_comb begin
      state_in = state_ff;
      len_in   = csr_we ? csr_wdata : len_ff;
      px_in = px_ff; py_in = py_ff; bx_in = bx_ff; by_in = by_ff;
      have_in = have_ff;
      dx_in = dx_ff; dy_in = dy_ff;
      sum_in = sum_ff; sq_in = sq_ff;
      n_in = n_ff; i_in = i_ff; ph_in = ph_ff;
      ox_in = ox_ff; oy_in = oy_ff; qx_in = qx_ff; qy_in = qy_ff;
      olast_in = olast_ff;
      ov_in = ov_ff && !rsp.ready;
      mstart = 1'b0; ma = '0; mb = '0;
      dstart = 1'b0; dnum = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               bx_in = req.x;
               by_in = req.y;
               if (req.flag || !have_ff) begin
                  ox_in = req.x; oy_in = req.y; olast_in = 1'b1; ov_in = 1'b1;
                  px_in = req.x; py_in = req.y; have_in = 1'b1;
               end else begin
                  dx_in = DXW'(req.x) - DXW'(px_ff);
                  dy_in = DXW'(req.y) - DXW'(py_ff);
                  ph_in = 2'd0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            ma = ph_ff[0] ? MW'(ady) : MW'(adx);
            mb = ma;
            if (ph_ff[1] == 1'b0) begin
               mstart = 1'b1;
               ph_in = {1'b1, ph_ff[0]};
            end else if (mdone) begin
               if (!ph_ff[0]) begin
                  sum_in = mprod;
                  ph_in = 2'd1;
               end else begin
                  sum_in = sum_ff + mprod;
                  i_in = NW'(1);
                  ph_in = 2'd0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // ph 0: start i*len, ph 1: wait for it, ph 2: start square, ph 3: compare
            if (ph_ff == 2'd0) begin
               ma = MW'(i_ff); mb = MW'(len_ff); mstart = 1'b1; ph_in = 2'd1;
            end else if (ph_ff == 2'd1) begin
               if (mdone) begin
                  sq_in = mprod; ph_in = 2'd2;
               end
            end else if (ph_ff == 2'd2) begin
               ma = MW'(sq_ff); mb = MW'(sq_ff); mstart = 1'b1; ph_in = 2'd3;
            end else if (mdone) begin
               if (mprod >= sum_ff || i_ff == NW'(MAX_INTERVALS)) begin
                  n_in = i_ff;
                  i_in = NW'(1);
                  ph_in = 2'd0;
                  state_in = (i_ff == NW'(1)) ? ST_LAST : ST_DIV;
               end else begin
                  i_in = i_ff + 1'b1;
                  ph_in = 2'd0;
               end
            end
         end
         ST_DIV: begin
            if (ph_ff == 2'd0 || ph_ff == 2'd2) begin
               dnum = (ph_ff == 2'd0) ? QW'(dx_ff) * $signed({1'b0, i_ff})
                                      : QW'(dy_ff) * $signed({1'b0, i_ff});
               dstart = 1'b1;
               ph_in = ph_ff + 1'b1;
            end else if (ddone) begin
               if (ph_ff == 2'd1) begin
                  qx_in = COORD_BITS'(px_ff + COORD_BITS'(dquo));
                  ph_in = 2'd2;
               end else begin
                  qy_in = COORD_BITS'(py_ff + COORD_BITS'(dquo));
                  ph_in = 2'd0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!ov_ff) begin
               ox_in = qx_ff; oy_in = qy_ff; olast_in = 1'b0;
               ov_in = 1'b1;
               i_in = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 == n_ff) ? ST_LAST : ST_DIV;
            end
         end
         ST_LAST: begin
            if (!ov_ff) begin
               ox_in = bx_ff; oy_in = by_ff; olast_in = 1'b1; ov_in = 1'b1;
               px_in = bx_ff; py_in = by_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= LEN_RESET;
         have_ff  <= 1'b0;
         px_ff    <= '0;
         py_ff    <= '0;
         ov_ff    <= 1'b0;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         have_ff  <= have_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         ov_ff    <= ov_in;
         ph_ff    <= ph_in;
      end
      bx_ff <= bx_in; by_ff <= by_in;
      dx_ff <= dx_in; dy_ff <= dy_in;
      sum_ff <= sum_in; sq_ff <= sq_in;
      n_ff <= n_in; i_ff <= i_in;
      ox_ff <= ox_in; oy_ff <= oy_in; qx_ff <= qx_in; qy_ff <= qy_in;
      olast_ff <= olast_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_beat_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.x) && $stable(rsp.y)))
      else $error("output beat changed while stalled");
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (i_ff < n_ff)) else $error("index past count");
endmodule

@@ test/tb_polyline_segment_subdivider_core.sv @@
// Testbench: self-checking regression for the polyline segment subdivider core.
`timescale 1ns / 1ps
module tb_polyline_segment_subdivider_core;
   import pss_pkg::*;

   localparam int CB    = COORD_BITS_DEF;
   localparam int NMAX  = MAX_INTERVALS_DEF;
   localparam longint CMIN = -(longint'(1) << (CB - 1));
   localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic                 last;
   } point_beat_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [LEN_BITS-1:0] csr_wdata;

   pss_if #(.COORD_BITS(CB)) req_if ();
   pss_if #(.COORD_BITS(CB)) rsp_if ();

   polyline_segment_subdivider_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [LEN_BITS-1:0] seg_len;
   longint              anchor_x;
   longint              anchor_y;
   bit                  anchor_valid;
   point_beat_type      pending_points[$];

   int mismatches = 0;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("polyline_segment_subdivider_core regression: fail");
      $finish;
   end

   task automatic enqueue_beat(input point_beat_type beat);
      pending_points.insert(pending_points.size(), beat);
   endtask

   // expected output points for one input point
   task automatic predict_subdivision(input longint bx, input longint by, input bit start);
      longint dx, dy, dist_sq, nl, n;
      point_beat_type beat;
      if (start || !anchor_valid) begin
         beat = '{x: bx[CB-1:0], y: by[CB-1:0], last: 1'b1};
         enqueue_beat(beat);
      end else begin
         dx = bx - anchor_x;
         dy = by - anchor_y;
         dist_sq = dx * dx + dy * dy;
         n = NMAX;
         for (longint i = 1; i <= NMAX; i++) begin
            nl = i * longint'(seg_len);
            if (nl * nl >= dist_sq) begin
               n = i;
               break;
            end
         end
         for (longint i = 1; i < n; i++) begin
            nl = anchor_x + (dx * i) / n;
            beat.x = nl[CB-1:0];
            nl = anchor_y + (dy * i) / n;
            beat.y = nl[CB-1:0];
            beat.last = 1'b0;
            enqueue_beat(beat);
         end
         beat = '{x: bx[CB-1:0], y: by[CB-1:0], last: 1'b1};
         enqueue_beat(beat);
      end
      anchor_x = bx;
      anchor_y = by;
      anchor_valid = 1'b1;
   endtask

   task automatic send_point(input longint bx, input longint by, input bit start);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      predict_subdivision(bx, by, start);
      req_if.valid <= 1'b1;
      req_if.x     <= bx[CB-1:0];
      req_if.y     <= by[CB-1:0];
      req_if.flag  <= start;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seg_len(input logic [LEN_BITS-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      seg_len = value;
   endtask

   function automatic longint clamp_coord(input longint v);
      if (v < CMIN) return CMIN;
      if (v > CMAX) return CMAX;
      return v;
   endfunction

   function automatic longint rand_coord();
      return longint'($signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8);
   endfunction

   // reset length 1.0: missing start, short, zero, long, extremes
   task automatic test_default_length();
      send_point(100, -100, 1'b0);
      send_point(100, -100, 1'b0);
      send_point(300, 0, 1'b0);
      send_point(400, 100, 1'b0);
      send_point(400, 1100, 1'b0);
      send_point(0, 0, 1'b1);
      send_point(-700, 500, 1'b0);
      send_point(CMIN, CMIN, 1'b1);
      send_point(CMAX, CMAX, 1'b0);
      send_point(CMIN, CMAX, 1'b0);
      send_point(CMAX, CMIN, 1'b0);
      wait_drained();
      send_point(CMAX, 0, 1'b0);
   endtask

   task automatic test_zero_length();
      write_seg_len('0);
      send_point(10, 10, 1'b1);
      send_point(10, 10, 1'b0);
      send_point(11, 10, 1'b0);
      send_point(-5000, 70000, 1'b0);
   endtask

   task automatic test_max_length();
      write_seg_len(LEN_MAX);
      send_point(CMIN, 0, 1'b1);
      send_point(CMAX, 0, 1'b0);
      send_point(CMAX, CMAX, 1'b0);
      send_point(CMIN, CMIN, 1'b0);
      write_seg_len(23'd1);
      send_point(0, 0, 1'b1);
      send_point(3, 4, 1'b0);
      send_point(-40, 4, 1'b0);
   endtask

   task automatic test_random_polylines();
      longint bx, by, span;
      int sent, run, pick;
      sent = 0;
      while (sent < 250) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       write_seg_len(LEN_BITS'($urandom_range(0, 23'h7FFFFF)));
            1:       write_seg_len(LEN_BITS'($urandom_range(0, 8)));
            default: write_seg_len(LEN_BITS'($urandom_range(16, 4096)));
         endcase
         run = $urandom_range(2, 12);
         for (int k = 0; k < run; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               bx = rand_coord();
               by = rand_coord();
            end else begin
               span = longint'(seg_len) * $urandom_range(0, 40) + $urandom_range(0, 3);
               if (span > CMAX) span = CMAX;
               bx = clamp_coord(anchor_x + longint'($urandom_range(0, 2 * span)) - span);
               by = clamp_coord(anchor_y + longint'($urandom_range(0, 2 * span)) - span);
            end
            send_point(bx, by, k == 0 || $urandom_range(0, 29) == 0);
            sent++;
         end
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
   endtask

   // result sink with its own stall pattern
   int stall_mode;
   int stall_count;
   always @(posedge clock) begin
      point_beat_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode   <= 0;
         stall_count  <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= (stall_count % 4) == 0;
            default: rsp_if.ready <= $urandom_range(0, 7) != 0;
         endcase
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat x=%0d y=%0d last=%0b",
                           rsp_if.x, rsp_if.y, rsp_if.flag);
            end else begin
               want = pending_points.pop_front();
               if (rsp_if.x !== want.x || rsp_if.y !== want.y || rsp_if.flag !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                              want.x, want.y, want.last, rsp_if.x, rsp_if.y, rsp_if.flag);
               end
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.x     = '0;
      req_if.y     = '0;
      req_if.flag  = 1'b0;
      seg_len      = LEN_RESET;
      anchor_x     = 0;
      anchor_y     = 0;
      anchor_valid = 1'b0;
      burst_left   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_length();
      test_zero_length();
      test_max_length();
      test_random_polylines();
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_points.size() == 0)
         $display("polyline_segment_subdivider_core regression: pass");
      else
         $display("polyline_segment_subdivider_core regression: fail");
      $finish;
   end
endmodule
